FILE: sv/cpu_utilization_meter_core_defines.svh
// Assertion macros for the processor utilization meter.
// Included by the top level only; depends on nothing else.
`ifndef CPU_UTILIZATION_METER_CORE_DEFINES_SVH
`define CPU_UTILIZATION_METER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPUUM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpuum: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPUUM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpuum: next-cycle check failed");

`endif

FILE: sv/cpuum_pkg.sv
// Shared types and constants of the processor utilization meter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cpuum_pkg;

    localparam int unsigned FIELD_W  = 64;
    localparam int unsigned USAGE_W  = 14;
    localparam int unsigned NUM_CNT  = 8;
    localparam int unsigned IDX_W    = 3;

    localparam logic [USAGE_W-1:0] FULL_SCALE = 14'd10000;

    // Positions of the two counters that make up the idle sum.
    localparam logic [IDX_W-1:0] IDX_IDLE   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_IOWAIT = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LAST   = 3'd7;

    // Result selection codes.
    localparam logic [1:0] RES_DIV   = 2'd0;
    localparam logic [1:0] RES_ZERO  = 2'd1;
    localparam logic [1:0] RES_FIRST = 2'd2;
    localparam logic [1:0] RES_SAT   = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] user_ticks;
        logic [FIELD_W-1:0] nice_ticks;
        logic [FIELD_W-1:0] sys_ticks;
        logic [FIELD_W-1:0] idle_ticks;
        logic [FIELD_W-1:0] iowait_ticks;
        logic [FIELD_W-1:0] irq_ticks;
        logic [FIELD_W-1:0] softirq_ticks;
        logic [FIELD_W-1:0] steal_ticks;
    } snap_t;

    typedef struct packed {
        logic [USAGE_W-1:0] usage_hundredths;
        logic               first_sample;
        logic               saturated;
    } usage_t;

    typedef struct packed {
        logic       capture;
        logic       sum_step;
        logic       sum_idle;
        logic       sum_clear;
        logic       delta;
        logic       cmp;
        logic       mul;
        logic       div_step;
        logic       load_out;
        logic [1:0] res_sel;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic dtot_zero;
        logic idle_gt;
    } status_t;

endpackage

FILE: sv/cpuum_snap_if.sv
// Request channel carrying one snapshot of the eight time counters.
// Depends on cpuum_pkg for the payload type.
interface cpuum_snap_if;
    import cpuum_pkg::*;

    logic  valid;
    logic  ready;
    snap_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cpuum_usage_if.sv
// Request channel carrying one utilization result.
// Depends on cpuum_pkg for the payload type.
interface cpuum_usage_if;
    import cpuum_pkg::*;

    logic   valid;
    logic   ready;
    usage_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cpu_utilization_meter_core.sv
// Processor utilization meter. Each request carries one snapshot of eight
// cumulative time counters; the block answers with the busy share since the
// previous snapshot in hundredths of a percent, plus flags for the first
// snapshot after reset and for an idle delta larger than the total delta.
// One snapshot is worked on at a time. A snapshot that needs a division runs
// through the summing, delta, compare and multiply steps and then through the
// bit-serial restoring divider, which retires one quotient bit per cycle over
// COUNTER_WIDTH + 14 steps. First, zero-delta and saturated snapshots skip
// the multiply and the divide and go straight to the output. A finished
// result waits in an output register, and the next snapshot is accepted while
// it waits.
`include "cpu_utilization_meter_core_defines.svh"

module cpu_utilization_meter_core #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    cpuum_snap_if.sink     snap,
    cpuum_usage_if.source  usage
);
    import cpuum_pkg::*;

    cmd_t    cmd;
    status_t status;

    cpuum_ctrl #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_valid  (snap.valid),
        .snap_ready  (snap.ready),
        .usage_valid (usage.valid),
        .usage_ready (usage.ready),
        .status      (status),
        .cmd         (cmd)
    );

    cpuum_dpath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .snap_data  (snap.data),
        .status     (status),
        .usage_data (usage.data)
    );

    `CPUUM_ASSERT_NEXT(a_busy_after_accept, snap.valid && snap.ready, !snap.ready)
    `CPUUM_ASSERT_NOW(a_usage_in_range, usage.valid, usage.data.usage_hundredths <= FULL_SCALE)
    `CPUUM_ASSERT_NOW(a_sat_full_scale, usage.valid && usage.data.saturated, usage.data.usage_hundredths == FULL_SCALE && !usage.data.first_sample)
    `CPUUM_ASSERT_NOW(a_first_zero, usage.valid && usage.data.first_sample, usage.data.usage_hundredths == '0)

endmodule

FILE: sv/cpuum_ctrl.sv
// Sequencing state machine of the utilization meter: summing, deltas, compare, multiply, divide, output.
// Depends on cpuum_pkg for the command and status structs.
module cpuum_ctrl #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    output logic               usage_valid,
    input  logic               usage_ready,
    input  cpuum_pkg::status_t status,
    output cpuum_pkg::cmd_t    cmd
);
    import cpuum_pkg::*;

    localparam int unsigned DIV_STEPS = COUNTER_WIDTH + USAGE_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DELTA = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       sel_reg, sel_next;
    logic             oval_reg, oval_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        oval_next  = oval_reg & ~usage_ready;
        cmd        = '0;
        cmd.res_sel = sel_reg;
        snap_ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                snap_ready = 1'b1;
                if (snap_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.sum_clear = 1'b1;
                    idx_next      = '0;
                    state_next    = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.sum_idle = (idx_reg == IDX_IDLE) || (idx_reg == IDX_IOWAIT);
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // First sample outranks a zero delta, which outranks saturation.
                cmd.cmp = 1'b1;
                if (status.first)
                begin
                    sel_next   = RES_FIRST;
                    state_next = S_FIN;
                end
                else if (status.dtot_zero)
                begin
                    sel_next   = RES_ZERO;
                    state_next = S_FIN;
                end
                else if (status.idle_gt)
                begin
                    sel_next   = RES_SAT;
                    state_next = S_FIN;
                end
                else
                begin
                    sel_next   = RES_DIV;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Wait for the output register to drain before overwriting it.
                if (!oval_reg || usage_ready)
                begin
                    cmd.load_out = 1'b1;
                    oval_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            sel_reg   <= RES_ZERO;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            oval_reg  <= oval_next;
        end
    end

    assign usage_valid = oval_reg;

endmodule

FILE: sv/cpuum_dpath.sv
// Datapath of the utilization meter: snapshot shift line, sums, deltas,
// scaling multiply, restoring divider and output register. Depends on cpuum_pkg.
module cpuum_dpath #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cpuum_pkg::cmd_t     cmd,
    input  cpuum_pkg::snap_t    snap_data,
    output cpuum_pkg::status_t  status,
    output cpuum_pkg::usage_t   usage_data
);
    import cpuum_pkg::*;

    localparam int unsigned W  = COUNTER_WIDTH;
    localparam int unsigned PW = COUNTER_WIDTH + USAGE_W;

    logic [W-1:0]       snap_reg [NUM_CNT];
    logic [W-1:0]       total_reg, idle_reg;
    logic [W-1:0]       prev_total_reg, prev_idle_reg;
    logic               base_reg;
    logic               first_reg;
    logic [W-1:0]       dtot_reg, didle_reg, num_reg;
    logic [PW-1:0]      prod_reg;
    logic [W-1:0]       rem_reg;
    logic [USAGE_W-1:0] quo_reg;
    usage_t             out_reg;

    logic [W:0]         trial;
    logic [W:0]         trial_diff;
    logic               trial_ge;
    usage_t             out_next;

    // Each divide step brings in one dividend bit; the partial remainder
    // stays below the divisor, so it fits in W bits.
    assign trial      = {rem_reg, prod_reg[PW-1]};
    assign trial_diff = trial - {1'b0, dtot_reg};
    assign trial_ge   = ~trial_diff[W];

    assign status.first     = first_reg;
    assign status.dtot_zero = (dtot_reg == '0);
    assign status.idle_gt   = (didle_reg > dtot_reg);

    always_comb
    begin
        out_next = '0;
        case (cmd.res_sel)
            RES_DIV:
            begin
                out_next.usage_hundredths = quo_reg;
            end
            RES_SAT:
            begin
                out_next.usage_hundredths = FULL_SCALE;
                out_next.saturated        = 1'b1;
            end
            RES_FIRST:
            begin
                out_next.first_sample = 1'b1;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Baseline state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_total_reg <= '0;
            prev_idle_reg  <= '0;
            base_reg       <= 1'b0;
        end
        else if (cmd.delta)
        begin
            prev_total_reg <= total_reg;
            prev_idle_reg  <= idle_reg;
            base_reg       <= 1'b1;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            snap_reg[0] <= snap_data.user_ticks[W-1:0];
            snap_reg[1] <= snap_data.nice_ticks[W-1:0];
            snap_reg[2] <= snap_data.sys_ticks[W-1:0];
            snap_reg[3] <= snap_data.idle_ticks[W-1:0];
            snap_reg[4] <= snap_data.iowait_ticks[W-1:0];
            snap_reg[5] <= snap_data.irq_ticks[W-1:0];
            snap_reg[6] <= snap_data.softirq_ticks[W-1:0];
            snap_reg[7] <= snap_data.steal_ticks[W-1:0];
        end
        else if (cmd.sum_step)
        begin
            for (int i = 0; i < NUM_CNT - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end

        if (cmd.sum_clear)
        begin
            total_reg <= '0;
            idle_reg  <= '0;
        end
        else if (cmd.sum_step)
        begin
            total_reg <= total_reg + snap_reg[0];
            if (cmd.sum_idle)
            begin
                idle_reg <= idle_reg + snap_reg[0];
            end
        end

        if (cmd.delta)
        begin
            dtot_reg  <= total_reg - prev_total_reg;
            didle_reg <= idle_reg - prev_idle_reg;
            first_reg <= ~base_reg;
        end

        if (cmd.cmp)
        begin
            num_reg <= dtot_reg - didle_reg;
        end

        if (cmd.mul)
        begin
            prod_reg <= PW'(num_reg) * PW'(FULL_SCALE);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
            quo_reg  <= {quo_reg[USAGE_W-2:0], trial_ge};
        end

        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign usage_data = out_reg;

endmodule
